// File: src/qphs_pkg.sv
// Shared types, codes and constants for the quadratic-probe hash set.
package qphs_pkg;

  // Default sizing
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_MAX_PROBES  = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int MARK_W   = 2;

  // Key remainder unit: bits retired per cycle
  localparam int MOD_STEP_BITS = 4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 1'd1;
  localparam logic [CFG_W-1:0]     TABLE_SIZE_RST = 11'd1024;
  localparam logic [CFG_W-1:0]     LOAD_LIMIT_RST = 11'd768;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd5;

  // Slot marks
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FIRST,
    ST_PROBE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                overloaded;
  } res_t;

  // Handshake between controller and remainder unit
  typedef struct packed {
    logic start;
  } mod_req_t;

  typedef struct packed {
    logic done;
  } mod_rsp_t;

endpackage

// File: src/qphs_stream_if.sv
// Valid/ready channel carrying one payload per transfer.
interface qphs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/qphs_slot_mem.sv
// Single-port-write, single-port-read slot store with registered read data.
module qphs_slot_mem #(
  parameter int DEPTH  = qphs_pkg::DEF_TABLE_DEPTH,
  parameter int WIDTH  = qphs_pkg::MARK_W + qphs_pkg::KEY_W,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/qphs_mod_unit.sv
// Iterative key remainder: restoring division, MOD_STEP_BITS quotient bits per cycle.
module qphs_mod_unit #(
  parameter int DIVD_W = qphs_pkg::KEY_W,
  parameter int DIVS_W = qphs_pkg::CFG_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qphs_pkg::mod_req_t   req_i,
  input  logic [DIVD_W-1:0]    dividend_i,
  input  logic [DIVS_W-1:0]    divisor_i,
  output qphs_pkg::mod_rsp_t   rsp_o,
  output logic [DIVS_W-1:0]    rem_o
);

  localparam int SB    = qphs_pkg::MOD_STEP_BITS;
  localparam int STEPS = (DIVD_W + SB - 1) / SB;
  localparam int PAD_W = STEPS * SB;
  localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_q, done_q;
  logic [SCW-1:0]    cnt_q;
  logic [PAD_W-1:0]  num_q;
  logic [DIVS_W-1:0] den_q;
  logic [DIVS_W-1:0] rem_q, rem_d;

  always_comb begin
    logic [DIVS_W:0]   r_ext;
    logic [DIVS_W-1:0] r;
    r = rem_q;
    for (int i = 0; i < SB; i++) begin
      r_ext = {r, num_q[PAD_W-1-i]};
      if (r_ext >= {1'b0, den_q}) begin
        r_ext = r_ext - {1'b0, den_q};
      end
      r = r_ext[DIVS_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + SCW'(1);
        if (cnt_q == SCW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= PAD_W'(dividend_i);
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << SB;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rem_o      = rem_q;

endmodule

// File: src/quadratic_probe_hash_set.sv
// Top level: quadratic-probe hash set controller around the slot store.
//
//  channel   dir  fields                               transfer when
//  cmd_i     in   command[1:0] key[30:0]               valid && ready
//  res_o     out  status[2:0] slot_index[9:0] overld   valid && ready
//  cfg       in   cfg_we_i cfg_idx_i cfg_data_i[10:0]  cfg_we_i high
//
// After reset the slot store is swept empty, slot by slot, with cmd_i not
// ready. An operation then runs in order: idle takes the command, the key
// remainder unit runs (4 bits a cycle), the store is primed, 1..MAX_PROBES
// probes follow with the next read issued ahead, and the result is loaded.
// An unknown command goes from idle straight to the result load. cmd_i is
// taken again while a result still waits in the output register; a stalled
// result only holds the next item at its result load.
module quadratic_probe_hash_set #(
  parameter int TABLE_DEPTH = qphs_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PROBES  = qphs_pkg::DEF_MAX_PROBES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qphs_stream_if.sink                   cmd_i,
  qphs_stream_if.source                 res_o,
  input  logic                          cfg_we_i,
  input  logic [qphs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [qphs_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int KEY_W  = qphs_pkg::KEY_W;
  localparam int MARK_W = qphs_pkg::MARK_W;
  localparam int CFG_W  = qphs_pkg::CFG_W;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
  localparam int SZC_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
  localparam int PW     = SIZE_W + 1;
  localparam int CW     = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int WORD_W = MARK_W + KEY_W;

  qphs_pkg::state_e state_q, state_d;

  logic [CFG_W-1:0]    tsize_q, limit_q;
  logic [SIZE_W-1:0]   live_size;
  logic [SIZE_W-1:0]   count_q;

  logic [qphs_pkg::CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [IDX_W-1:0]    p_q, inc_q, p_next, inc_next, inc_first;
  logic [CW-1:0]       c_q;
  logic                have_free_q;
  logic [IDX_W-1:0]    free_q;
  logic [IDX_W-1:0]    clr_q;

  logic [qphs_pkg::STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    slot_q, slot_d;

  logic                out_valid_q;
  qphs_pkg::res_t      out_q;

  qphs_pkg::mod_req_t  mod_req;
  qphs_pkg::mod_rsp_t  mod_rsp;
  logic [SIZE_W-1:0]   home;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata;

  logic                accept, known_cmd, finish, clr_last, load_out;
  logic                used, gone, hit, stop, last_probe, free_eff;
  logic [IDX_W-1:0]    free_slot;
  logic [MARK_W-1:0]   rd_mark;
  logic [KEY_W-1:0]    rd_key;
  logic                cnt_up, cnt_down;

  // (x + 2) mod size, x already below size
  function automatic logic [IDX_W-1:0] step_mod(input logic [IDX_W-1:0] x,
                                                input logic [SIZE_W-1:0] sz);
    logic [PW-1:0] t;
    t = PW'(x) + PW'(2);
    if (t >= PW'(sz)) t = t - PW'(sz);
    if (t >= PW'(sz)) t = t - PW'(sz);
    return IDX_W'(t);
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= qphs_pkg::TABLE_SIZE_RST;
      limit_q <= qphs_pkg::LOAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qphs_pkg::CFG_TABLE_SIZE: tsize_q <= cfg_data_i;
        qphs_pkg::CFG_LOAD_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tsize_q == '0) begin
      live_size = SIZE_W'(1);
    end else if (SZC_W'(tsize_q) > SZC_W'(TABLE_DEPTH)) begin
      live_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      live_size = SIZE_W'(tsize_q);
    end
  end

  // ---------------------------------------------------------------- units
  qphs_mod_unit #(
    .DIVD_W (KEY_W),
    .DIVS_W (SIZE_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mod_req),
    .dividend_i (cmd_i.data.key),
    .divisor_i  (live_size),
    .rsp_o      (mod_rsp),
    .rem_o      (home)
  );

  qphs_slot_mem #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ------------------------------------------------------- probe datapath
  assign rd_mark = mem_rdata[KEY_W +: MARK_W];
  assign rd_key  = mem_rdata[KEY_W-1:0];
  assign used    = (rd_mark == qphs_pkg::MARK_USED);
  assign gone    = (rd_mark == qphs_pkg::MARK_GONE);
  assign hit     = used && (rd_key == key_q);
  assign last_probe = (c_q == CW'(MAX_PROBES - 1));
  assign stop    = hit || (!used && !gone) || last_probe;
  assign free_eff  = have_free_q || !used;
  assign free_slot = have_free_q ? free_q : p_q;

  always_comb begin
    logic [PW-1:0] s;
    s = PW'(p_q) + PW'(inc_q);
    if (s >= PW'(live_size)) s = s - PW'(live_size);
    p_next    = IDX_W'(s);
    inc_next  = step_mod(inc_q, live_size);
    inc_first = step_mod('0, live_size);
  end

  assign known_cmd = (cmd_i.data.command == qphs_pkg::CMD_ADD)
                  || (cmd_i.data.command == qphs_pkg::CMD_SEARCH)
                  || (cmd_i.data.command == qphs_pkg::CMD_DELETE);
  assign clr_last  = (clr_q == IDX_W'(TABLE_DEPTH - 1));
  assign load_out  = (state_q == qphs_pkg::ST_DONE) && (!out_valid_q || res_o.ready);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qphs_pkg::ST_CLEAR: if (clr_last) state_d = qphs_pkg::ST_IDLE;
      qphs_pkg::ST_IDLE: begin
        if (cmd_i.valid) state_d = known_cmd ? qphs_pkg::ST_HASH : qphs_pkg::ST_DONE;
      end
      qphs_pkg::ST_HASH:  if (mod_rsp.done) state_d = qphs_pkg::ST_FIRST;
      qphs_pkg::ST_FIRST: state_d = qphs_pkg::ST_PROBE;
      qphs_pkg::ST_PROBE: if (stop) state_d = qphs_pkg::ST_DONE;
      qphs_pkg::ST_DONE:  if (load_out) state_d = qphs_pkg::ST_IDLE;
      default: state_d = qphs_pkg::ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    cmd_i.ready   = 1'b0;
    mod_req.start = 1'b0;
    finish        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = p_q;
    mem_wdata     = {qphs_pkg::MARK_EMPTY, KEY_W'(0)};
    mem_raddr     = p_q;
    status_d      = qphs_pkg::ST_NOTFOUND;
    slot_d        = '0;
    cnt_up        = 1'b0;
    cnt_down      = 1'b0;
    case (state_q)
      qphs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      qphs_pkg::ST_IDLE: begin
        cmd_i.ready   = 1'b1;
        mod_req.start = cmd_i.valid && known_cmd;
        finish        = cmd_i.valid && !known_cmd;
      end
      qphs_pkg::ST_PROBE: begin
        // read ahead; discarded if this probe ends the walk
        mem_raddr = p_next;
        finish    = stop;
        if (cmd_q == qphs_pkg::CMD_ADD) begin
          if (hit) begin
            status_d = qphs_pkg::ST_PRESENT;
            slot_d   = p_q;
          end else if (free_eff) begin
            status_d  = qphs_pkg::ST_INSERTED;
            slot_d    = free_slot;
            mem_we    = stop;
            mem_waddr = free_slot;
            mem_wdata = {qphs_pkg::MARK_USED, key_q};
            cnt_up    = stop;
          end else begin
            status_d = qphs_pkg::ST_LIMIT;
          end
        end else if (hit) begin
          slot_d = p_q;
          if (cmd_q == qphs_pkg::CMD_DELETE) begin
            status_d  = qphs_pkg::ST_DELETED;
            mem_we    = 1'b1;
            mem_wdata = {qphs_pkg::MARK_GONE, KEY_W'(0)};
            cnt_down  = (count_q != '0);
          end else begin
            status_d = qphs_pkg::ST_FOUND;
          end
        end
      end
      default: ;
    endcase
  end

  assign accept = cmd_i.valid && cmd_i.ready;

  // ---------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qphs_pkg::ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == qphs_pkg::ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (cnt_up) begin
        count_q <= count_q + SIZE_W'(1);
      end else if (cnt_down) begin
        count_q <= count_q - SIZE_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.data.command;
      key_q <= cmd_i.data.key;
    end
    if (mod_rsp.done) begin
      p_q         <= IDX_W'(home);
      inc_q       <= inc_first;
      c_q         <= '0;
      have_free_q <= 1'b0;
    end else if (state_q == qphs_pkg::ST_PROBE) begin
      p_q   <= p_next;
      inc_q <= inc_next;
      c_q   <= c_q + CW'(1);
      if (!used && !have_free_q) begin
        have_free_q <= 1'b1;
        free_q      <= p_q;
      end
    end
    if (finish) begin
      status_q <= status_d;
      slot_q   <= slot_d;
    end
    if (load_out) begin
      out_q.status     <= status_q;
      out_q.slot_index <= qphs_pkg::SLOT_W'(slot_q);
      out_q.overloaded <= SZC_W'(count_q) > SZC_W'(limit_q);
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // ------------------------------------------------------------ assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SIZE_W'(TABLE_DEPTH))
    else $error("occupied count above table depth");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qphs_pkg::ST_PROBE) |-> (SIZE_W'(p_q) < live_size))
    else $error("probe slot outside live table");

  a_write_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == qphs_pkg::ST_PROBE) |=> (state_q == qphs_pkg::ST_DONE))
    else $error("slot write without ending the walk");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == qphs_pkg::ST_DONE))
    else $error("result raised outside result load");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qphs_pkg::ST_CLEAR) |=> !$past(mod_req.start) && !out_valid_q)
    else $error("activity during store clearing");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the quadratic-probe hash set: predictor, stimulus and result checks.
module tb_top;
  import qphs_pkg::*;

  localparam int DEPTH      = DEF_TABLE_DEPTH;
  localparam int PROBES     = DEF_MAX_PROBES;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_OFF   = 400;
  localparam int PHASE_LEN  = 112;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  qphs_stream_if #(.payload_t(cmd_t)) cmd_if ();
  qphs_stream_if #(.payload_t(res_t)) res_if ();

  quadratic_probe_hash_set dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the slot store and registers
  logic [KEY_W-1:0]  set_keys  [DEPTH];
  logic [MARK_W-1:0] set_marks [DEPTH];
  int unsigned       set_count;
  logic [CFG_W-1:0]  set_size;
  logic [CFG_W-1:0]  set_limit;

  res_t awaited_res_q [$];
  int   errors;
  int   idle_cycles;
  bit   hold_off_req;
  bit   gaps_on;
  int   burst_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [CFG_W-1:0] size);
    if (size == 0) return 1;
    if (size > DEPTH) return DEPTH;
    return size;
  endfunction

  // Applies one command to the shadow set and returns the result it should give
  function automatic res_t hash_set_step(cmd_t item);
    int unsigned size;
    int unsigned home;
    int unsigned p;
    int unsigned slot;
    int unsigned free_slot;
    int          c;
    bit          have_free;
    bit          stop;
    logic [STATUS_W-1:0] status;
    res_t        r;
    size      = eff_size(set_size);
    home      = item.key % size;
    status    = ST_NOTFOUND;
    slot      = 0;
    free_slot = 0;
    have_free = 1'b0;
    stop      = 1'b0;
    if (item.command == CMD_ADD) begin
      for (c = 0; c < PROBES && !stop; c++) begin
        p = (home + c * (c + 1)) % size;
        if (set_marks[p] == MARK_USED) begin
          if (set_keys[p] == item.key) begin
            status = ST_PRESENT;
            slot   = p;
            stop   = 1'b1;
          end
        end else begin
          if (!have_free) begin
            have_free = 1'b1;
            free_slot = p;
          end
          if (set_marks[p] != MARK_GONE) stop = 1'b1;
        end
      end
      if (status != ST_PRESENT) begin
        if (have_free) begin
          set_keys[free_slot]  = item.key;
          set_marks[free_slot] = MARK_USED;
          set_count++;
          status = ST_INSERTED;
          slot   = free_slot;
        end else begin
          status = ST_LIMIT;
        end
      end
    end else if (item.command == CMD_SEARCH || item.command == CMD_DELETE) begin
      for (c = 0; c < PROBES && !stop; c++) begin
        p = (home + c * (c + 1)) % size;
        if (set_marks[p] == MARK_USED) begin
          if (set_keys[p] == item.key) begin
            slot = p;
            stop = 1'b1;
            if (item.command == CMD_SEARCH) begin
              status = ST_FOUND;
            end else begin
              set_marks[p] = MARK_GONE;
              set_keys[p]  = '0;
              if (set_count > 0) set_count--;
              status = ST_DELETED;
            end
          end
        end else if (set_marks[p] != MARK_GONE) begin
          stop = 1'b1;
        end
      end
    end
    r.status     = status;
    r.slot_index = slot[SLOT_W-1:0];
    r.overloaded = (set_count > set_limit);
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin : check_res
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_res_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                 res_if.data.status, res_if.data.slot_index, res_if.data.overloaded);
      end else begin
        want = awaited_res_q.pop_front();
        if (res_if.data.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   res_if.data.status);
        end
        if (res_if.data.slot_index !== want.slot_index) begin
          errors++;
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                   res_if.data.slot_index);
        end
        if (res_if.data.overloaded !== want.overloaded) begin
          errors++;
          $display("%0t: overloaded expected %0d actual %0d", $time, want.overloaded,
                   res_if.data.overloaded);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("quadratic_probe_hash_set: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: ready on a pattern of its own, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    bit held;
    res_if.ready = 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !held) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 150);
        end
        left--;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= ($urandom_range(0, 2) == 0);
          default: res_if.ready <= ((left / 4) % 2 == 0);
        endcase
      end
    end
  end

  // Bursts of random length separated by random gaps
  task automatic pace();
    int gap;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 11);
        gap = $urandom_range(1, 6);
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] command, logic [KEY_W-1:0] key);
    cmd_t item;
    item.command = command;
    item.key     = key;
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= item;
    do @(posedge clk_i); while (!cmd_if.ready);
    awaited_res_q.push_back(hash_set_step(item));
    pace();
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (awaited_res_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] size, logic [CFG_W-1:0] limit);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TABLE_SIZE;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LOAD_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    set_size  = size;
    set_limit = limit;
    @(posedge clk_i);
  endtask

  // Reset register values; key zero, tombstone reuse and collision chains
  task automatic test_basic_ops();
    gaps_on = 1'b1;
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_ADD, '0);
    send_cmd(CMD_ADD, '0);
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_DELETE, '0);
    send_cmd(CMD_SEARCH, '0);       // tombstone holding zero must not match
    send_cmd(CMD_ADD, '0);          // reuses the tombstone
    send_cmd(CMD_ADD, '1);          // home 1023
    send_cmd(CMD_ADD, 31'd1023);    // collides, wraps to slot 1
    send_cmd(CMD_DELETE, '1);
    send_cmd(CMD_SEARCH, 31'd1023); // walks past the tombstone
    send_cmd(CMD_ADD, 31'd1023);    // already present, count unchanged
    send_cmd(CMD_UNKNOWN, '1);
    send_cmd(CMD_DELETE, 31'd12345);
    drain();
  endtask

  // Tiny tables: probe limit, overload flag, sizes zero and above the store
  task automatic test_probe_limit();
    set_config(11'd1, 11'd0);
    send_cmd(CMD_ADD, 31'd5);
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_DELETE, 31'd5);
    send_cmd(CMD_DELETE, '0);
    send_cmd(CMD_ADD, 31'd5);
    send_cmd(CMD_ADD, 31'd6);
    set_config(11'd0, 11'd1024);
    send_cmd(CMD_SEARCH, 31'd5);
    set_config(11'd2047, 11'd2047);
    send_cmd(CMD_SEARCH, 31'd1023);
    send_cmd(CMD_ADD, 31'h4000_03FF);
    drain();
  endtask

  task automatic test_random_phase(int n, logic [CFG_W-1:0] size, logic [CFG_W-1:0] limit,
                                   bit with_gaps);
    logic [KEY_W-1:0] pool [16];
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    int unsigned      eff;
    int               sel;
    set_config(size, limit);
    gaps_on = with_gaps;
    eff = eff_size(size);
    // few homes, many keys apiece: long probe chains
    foreach (pool[i]) pool[i] = KEY_W'($urandom_range(0, 5) + eff * $urandom_range(0, 2000));
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)      command = CMD_ADD;
      else if (sel < 70) command = CMD_SEARCH;
      else if (sel < 95) command = CMD_DELETE;
      else               command = CMD_UNKNOWN;
      sel = $urandom_range(0, 99);
      if (sel < 75)      key = pool[$urandom_range(0, 15)];
      else if (sel < 92) key = KEY_W'($urandom);
      else if (sel < 96) key = '1;
      else               key = '0;
      send_cmd(command, key);
    end
    drain();
  endtask

  // Receiver holds off while items keep coming, so the input backs up
  task automatic test_backpressure();
    set_config(11'd1024, 11'd768);
    gaps_on = 1'b0;
    hold_off_req <= 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 1) != 0) send_cmd(CMD_ADD, KEY_W'($urandom_range(0, 3) * 1024));
      else send_cmd(CMD_SEARCH, KEY_W'($urandom_range(0, 3) * 1024));
    end
    drain();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_TABLE_SIZE;
    cfg_data_i   = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    hold_off_req = 1'b0;
    gaps_on      = 1'b0;
    burst_left   = 0;
    foreach (set_marks[i]) set_marks[i] = MARK_EMPTY;
    set_count = 0;
    set_size  = TABLE_SIZE_RST;
    set_limit = LOAD_LIMIT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_probe_limit();
    test_backpressure();
    test_random_phase(PHASE_LEN, 11'd1024, 11'd768, 1'b1);
    test_random_phase(PHASE_LEN, 11'd1, 11'd0, 1'b1);
    test_random_phase(PHASE_LEN, 11'd2, 11'd1, 1'b0);
    test_random_phase(PHASE_LEN, 11'd7, 11'd3, 1'b1);
    test_random_phase(PHASE_LEN, 11'd64, 11'd10, 1'b1);
    test_random_phase(PHASE_LEN, 11'd0, 11'd2047, 1'b0);
    test_random_phase(PHASE_LEN, 11'd2047, 11'd1024, 1'b1);
    test_random_phase(PHASE_LEN, 11'd13, 11'd5, 1'b1);
    test_random_phase(PHASE_LEN, 11'd300, 11'd20, 1'b1);

    drain();
    repeat (64) @(posedge clk_i);
    if (errors == 0) begin
      $display("quadratic_probe_hash_set: match");
    end else begin
      $display("quadratic_probe_hash_set: mismatch");
    end
    $finish;
  end

endmodule
